// ===== hdl/bmrs_pkg.sv =====
`default_nettype none

package bmrs_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int SEL_W    = 2;
   localparam int PRESS_W  = 20;
   localparam int POS_W    = 7;
   localparam int SHORT_W  = 16;
   localparam int RUN_W    = 20;
   localparam int CSR_W    = 20;
   localparam int CSR_IDX_W = 3;
   localparam int LED_W    = 3;
   localparam int RELAY_W  = 2;

   // default parameter values
   localparam int TIME_WIDTH_DEF   = 32;
   localparam int BLINK_PERIOD_DEF = 500;

   // register reset values
   localparam logic [SHORT_W-1:0] DEAD_TIME_RST   = SHORT_W'(500);
   localparam logic [RUN_W-1:0]   UP_RUN_RST      = RUN_W'(30000);
   localparam logic [RUN_W-1:0]   DOWN_RUN_RST    = RUN_W'(30000);
   localparam logic [SHORT_W-1:0] MID_LED_RST     = SHORT_W'(1000);
   localparam logic [SHORT_W-1:0] SHORT_PRESS_RST = SHORT_W'(500);

   // ends of the position range
   localparam logic [POS_W-1:0] POS_FULL = POS_W'(100);
   localparam logic [POS_W-1:0] POS_EMPTY = POS_W'(0);

   typedef enum logic [OP_W-1:0] {
      OP_TICK        = 2'd0,
      OP_PRESS       = 2'd1,
      OP_BLINK_START = 2'd2,
      OP_BLINK_STOP  = 2'd3
   } op_type;

   typedef enum logic [SEL_W-1:0] {
      SEL_TOP    = 2'd0,
      SEL_MID    = 2'd1,
      SEL_BOTTOM = 2'd2,
      SEL_NONE   = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      DIR_UP   = 2'd0,
      DIR_DOWN = 2'd1,
      DIR_STOP = 2'd2,
      DIR_NONE = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_MOVE = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEAD_TIME   = 3'd0,
      REG_UP_RUN      = 3'd1,
      REG_DOWN_RUN    = 3'd2,
      REG_MID_LED     = 3'd3,
      REG_SHORT_PRESS = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [SEL_W-1:0]   target_select;
      logic [PRESS_W-1:0] press_ms;
      logic [POS_W-1:0]   position_pct;
   } req_type;

   typedef struct packed {
      logic up_drive;
      logic down_drive;
      logic led_top;
      logic led_mid;
      logic led_lower;
      logic moving;
      logic waiting;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/blind_motor_relay_sequencer_unit.sv =====
// blind motor relay sequencer
//
// req channel (valid/ready) carries one item: a 1 ms tick, a button press,
// a blink start or a blink stop. every item yields exactly one rsp item with
// the relay and led levels and the moving/waiting flags after that item.
// latency: the rsp item is valid the cycle after the req item is accepted.
// throughput: one item per cycle while rsp_ready is high; all work is a few
// compares and counter updates between the state registers and the rsp register.
// req_ready is high while the rsp register is empty or being drained in the
// same cycle, so a stalled receiver holds the result and back-pressures req;
// no item is dropped or repeated.
// csr port: write csr_wdata into register csr_addr when csr_we is high;
// only write while no item is in flight.
// reset (synchronous, active high) restores the register defaults, clears
// the time counter, motion and blink state, and empties the rsp register.
`default_nettype none

module blind_motor_relay_sequencer_unit #(
   parameter int TIME_WIDTH   = bmrs_pkg::TIME_WIDTH_DEF,
   parameter int BLINK_PERIOD = bmrs_pkg::BLINK_PERIOD_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire bmrs_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output bmrs_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [bmrs_pkg::CSR_IDX_W-1:0] csr_addr,
   input  wire logic [bmrs_pkg::CSR_W-1:0]     csr_wdata
);
   import bmrs_pkg::*;

   // compare width covers both the elapsed time and the run limits
   localparam int CMP_W = (TIME_WIDTH > RUN_W) ? TIME_WIDTH : RUN_W;

   // configuration registers
   logic [SHORT_W-1:0] dead_time_ff, mid_led_ff, short_press_ff;
   logic [RUN_W-1:0]   up_run_ff, down_run_ff;

   // timing and motion state
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic [TIME_WIDTH-1:0] phase_mark_ff, phase_mark_in;
   logic [TIME_WIDTH-1:0] blink_mark_ff, blink_mark_in;
   logic [RUN_W-1:0]      run_limit_ff, run_limit_in;
   phase_type             phase_ff, phase_in;
   logic                  pending_ff, pending_in;
   dir_type               active_ff, active_in;
   logic                  mid_hold_ff, mid_hold_in;
   logic [RELAY_W-1:0]    relay_ff, relay_in;
   logic [LED_W-1:0]      led_ff, led_in;
   logic                  blink_on_ff, blink_on_in;
   sel_type               blink_led_ff, blink_led_in;
   logic                  blink_level_ff, blink_level_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_time_ff   <= DEAD_TIME_RST;
         up_run_ff      <= UP_RUN_RST;
         down_run_ff    <= DOWN_RUN_RST;
         mid_led_ff     <= MID_LED_RST;
         short_press_ff <= SHORT_PRESS_RST;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_addr))
            REG_DEAD_TIME:   dead_time_ff   <= csr_wdata[SHORT_W-1:0];
            REG_UP_RUN:      up_run_ff      <= csr_wdata[RUN_W-1:0];
            REG_DOWN_RUN:    down_run_ff    <= csr_wdata[RUN_W-1:0];
            REG_MID_LED:     mid_led_ff     <= csr_wdata[SHORT_W-1:0];
            REG_SHORT_PRESS: short_press_ff <= csr_wdata[SHORT_W-1:0];
            default: ;
         endcase
      end
   end

   // next state for one item; the steps run in program order
   always_comb begin
      logic [TIME_WIDTH-1:0] elapsed;
      logic [TIME_WIDTH-1:0] blink_elapsed;
      dir_type               dir;
      logic                  do_move;
      sel_type               sel;

      now_in         = now_ff;
      phase_mark_in  = phase_mark_ff;
      blink_mark_in  = blink_mark_ff;
      run_limit_in   = run_limit_ff;
      phase_in       = phase_ff;
      pending_in     = pending_ff;
      active_in      = active_ff;
      mid_hold_in    = mid_hold_ff;
      relay_in       = relay_ff;
      led_in         = led_ff;
      blink_on_in    = blink_on_ff;
      blink_led_in   = blink_led_ff;
      blink_level_in = blink_level_ff;
      elapsed        = '0;
      blink_elapsed  = '0;
      dir            = DIR_NONE;
      do_move        = 1'b0;
      sel            = sel_type'(req_data.target_select);

      case (op_type'(req_data.operation))
         OP_TICK: begin
            now_in        = now_ff + TIME_WIDTH'(1);
            elapsed       = now_in - phase_mark_ff;
            blink_elapsed = now_in - blink_mark_ff;
            if (phase_ff == PH_WAIT && CMP_W'(elapsed) >= CMP_W'(dead_time_ff)) begin
               // dead time over: energize the pending direction
               active_in     = dir_type'({1'b0, pending_ff});
               led_in[pending_ff ? 2 : 0] = 1'b1;
               relay_in[pending_ff ? 1 : 0] = 1'b1;
               phase_mark_in = now_in;
               run_limit_in  = pending_ff ? down_run_ff : up_run_ff;
               phase_in      = PH_MOVE;
            end else if (phase_ff == PH_MOVE &&
                         CMP_W'(elapsed) >= CMP_W'(run_limit_ff)) begin
               // run time over: same as a stop press
               relay_in      = '0;
               led_in        = 3'b010;
               active_in     = DIR_NONE;
               phase_mark_in = now_in;
               mid_hold_in   = 1'b1;
               phase_in      = PH_IDLE;
            end else if (mid_hold_ff && CMP_W'(elapsed) >= CMP_W'(mid_led_ff)) begin
               led_in[1]   = 1'b0;
               mid_hold_in = 1'b0;
            end
            if (blink_on_ff && CMP_W'(blink_elapsed) >= CMP_W'(BLINK_PERIOD)) begin
               blink_level_in = !blink_level_ff;
               if (blink_led_ff != SEL_NONE)
                  led_in[blink_led_ff] = !blink_level_ff;
               blink_mark_in = now_in;
            end
         end
         OP_PRESS: begin
            if (sel != SEL_NONE &&
                {4'b0, short_press_ff} > req_data.press_ms) begin
               case (sel)
                  SEL_TOP:    dir = DIR_UP;
                  SEL_MID:    dir = DIR_STOP;
                  SEL_BOTTOM: dir = DIR_DOWN;
                  default:    dir = DIR_NONE;
               endcase
               do_move = 1'b1;
            end
            if (do_move) begin
               if (phase_ff == PH_MOVE || dir == DIR_STOP) begin
                  // same direction while running is ignored
                  if (!(active_ff == DIR_UP && dir == DIR_UP) &&
                      !(active_ff == DIR_DOWN && dir == DIR_DOWN)) begin
                     relay_in      = '0;
                     led_in        = {1'b0, (dir == DIR_STOP) | led_ff[1], 1'b0};
                     active_in     = DIR_NONE;
                     phase_mark_in = now_ff;
                     mid_hold_in   = 1'b1;
                     phase_in      = PH_IDLE;
                  end
               end else if (phase_ff != PH_WAIT) begin
                  // end positions block the move
                  if (!(req_data.position_pct == POS_EMPTY && dir == DIR_DOWN) &&
                      !(req_data.position_pct >= POS_FULL && dir == DIR_UP)) begin
                     pending_in    = dir[0];
                     phase_mark_in = now_ff;
                     phase_in      = PH_WAIT;
                  end
               end
            end
         end
         OP_BLINK_START: begin
            if (!blink_on_ff) begin
               blink_on_in    = 1'b1;
               blink_led_in   = sel;
               blink_level_in = 1'b1;
            end else begin
               blink_level_in = !blink_level_ff;
            end
            if (sel != SEL_NONE)
               led_in[sel] = blink_level_in;
            blink_mark_in = now_ff;
         end
         OP_BLINK_STOP: begin
            blink_on_in  = 1'b0;
            blink_led_in = SEL_NONE;
            if (sel != SEL_NONE)
               led_in[sel] = 1'b0;
         end
         default: ;
      endcase
   end

   // result item from the next state
   always_comb begin
      rsp_in.up_drive   = relay_in[0];
      rsp_in.down_drive = relay_in[1];
      rsp_in.led_top    = led_in[0];
      rsp_in.led_mid    = led_in[1];
      rsp_in.led_lower  = led_in[2];
      rsp_in.moving     = (phase_in == PH_MOVE);
      rsp_in.waiting    = (phase_in == PH_WAIT);
      rsp_valid_in      = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= '0;
         phase_mark_ff  <= '0;
         blink_mark_ff  <= '0;
         run_limit_ff   <= '0;
         phase_ff       <= PH_IDLE;
         pending_ff     <= 1'b0;
         active_ff      <= DIR_NONE;
         mid_hold_ff    <= 1'b0;
         relay_ff       <= '0;
         led_ff         <= '0;
         blink_on_ff    <= 1'b0;
         blink_led_ff   <= SEL_NONE;
         blink_level_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            now_ff         <= now_in;
            phase_mark_ff  <= phase_mark_in;
            blink_mark_ff  <= blink_mark_in;
            run_limit_ff   <= run_limit_in;
            phase_ff       <= phase_in;
            pending_ff     <= pending_in;
            active_ff      <= active_in;
            mid_hold_ff    <= mid_hold_in;
            relay_ff       <= relay_in;
            led_ff         <= led_in;
            blink_on_ff    <= blink_on_in;
            blink_led_ff   <= blink_led_in;
            blink_level_ff <= blink_level_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept)
         rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== hdl/bmrs_checker.sv =====
`default_nettype none

module bmrs_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire bmrs_pkg::rsp_type rsp_data
);
   import bmrs_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // never drive both relays
   a_relay_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.up_drive && rsp_data.down_drive))
      else $error("both relays driven");

   // a relay is on exactly while moving, never while waiting
   a_relay_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.moving == (rsp_data.up_drive || rsp_data.down_drive))
                    && !(rsp_data.moving && rsp_data.waiting))
      else $error("relay levels disagree with motion flags");

   // a full result register with a stalled receiver blocks new items
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item accepted while result stalled");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind blind_motor_relay_sequencer_unit bmrs_checker u_bmrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== bench/blind_motor_relay_sequencer_unit_checker.sv =====
`timescale 1ns / 100ps

module blind_motor_relay_sequencer_unit_checker #(
   parameter int BLINK_PERIOD = bmrs_pkg::BLINK_PERIOD_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bmrs_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bmrs_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [bmrs_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [bmrs_pkg::CSR_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);
   import bmrs_pkg::*;

   localparam int TIME_W = TIME_WIDTH_DEF;
   localparam int REPORT_LIMIT = 10;

   // timing registers as the block holds them
   logic [SHORT_W-1:0] dead_ms, mid_ms, short_ms;
   logic [RUN_W-1:0]   up_ms, down_ms;

   // sequencer state
   logic [TIME_W-1:0] clock_ms, phase_since, blink_since;
   logic [RUN_W-1:0]  run_span;
   phase_type         motion;
   logic              go_down;
   dir_type           drive_dir;
   logic              mid_pending;
   logic [RELAY_W-1:0] relay_on;
   logic [LED_W-1:0]  led_on;
   logic              blinking;
   logic [SEL_W-1:0]  blink_sel;
   logic              blink_lvl;

   rsp_type levels_due[$];

   task automatic set_led(input logic [SEL_W-1:0] sel, input logic level);
      if (sel != SEL_NONE) led_on[sel] = level;
   endtask

   task automatic blink_apply(input logic [SEL_W-1:0] sel, input logic start);
      if (!start) begin
         blinking = 1'b0;
         blink_sel = SEL_NONE;
         set_led(sel, 1'b0);
      end else begin
         if (!blinking) begin
            blinking = 1'b1;
            blink_sel = sel;
            blink_lvl = 1'b1;
         end else begin
            blink_lvl = ~blink_lvl;
         end
         set_led(sel, blink_lvl);
         blink_since = clock_ms;
      end
   endtask

   task automatic motion_request(input dir_type dir, input logic [POS_W-1:0] pos);
      if (motion == PH_MOVE || dir == DIR_STOP) begin
         if (drive_dir == DIR_UP && dir == DIR_UP) return;
         if (drive_dir == DIR_DOWN && dir == DIR_DOWN) return;
         relay_on = '0;
         set_led(SEL_TOP, 1'b0);
         set_led(SEL_BOTTOM, 1'b0);
         drive_dir = DIR_NONE;
         phase_since = clock_ms;
         mid_pending = 1'b1;
         motion = PH_IDLE;
         if (dir == DIR_STOP) set_led(SEL_MID, 1'b1);
      end else if (motion != PH_WAIT) begin
         if (pos == POS_EMPTY && dir == DIR_DOWN) return;
         if (pos >= POS_FULL && dir == DIR_UP) return;
         go_down = (dir == DIR_DOWN);
         phase_since = clock_ms;
         motion = PH_WAIT;
      end
   endtask

   always @(posedge clock) begin
      rsp_type           want;
      logic [TIME_W-1:0] elapsed;
      dir_type           dir;
      if (reset) begin
         dead_ms = DEAD_TIME_RST;
         up_ms = UP_RUN_RST;
         down_ms = DOWN_RUN_RST;
         mid_ms = MID_LED_RST;
         short_ms = SHORT_PRESS_RST;
         clock_ms = '0;
         phase_since = '0;
         blink_since = '0;
         run_span = '0;
         motion = PH_IDLE;
         go_down = 1'b0;
         drive_dir = DIR_NONE;
         mid_pending = 1'b0;
         relay_on = '0;
         led_on = '0;
         blinking = 1'b0;
         blink_sel = SEL_NONE;
         blink_lvl = 1'b0;
         levels_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_DEAD_TIME:   dead_ms = csr_wdata[SHORT_W-1:0];
               REG_UP_RUN:      up_ms = csr_wdata[RUN_W-1:0];
               REG_DOWN_RUN:    down_ms = csr_wdata[RUN_W-1:0];
               REG_MID_LED:     mid_ms = csr_wdata[SHORT_W-1:0];
               REG_SHORT_PRESS: short_ms = csr_wdata[SHORT_W-1:0];
               default: ;
            endcase
         end

         // a result is registered after its item, so retire before predicting
         if (rsp_valid && rsp_ready) begin
            if (levels_due.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: result with no item outstanding: %b", $time, rsp_data);
            end else begin
               want = levels_due.pop_front();
               if (rsp_data.up_drive !== want.up_drive ||
                   rsp_data.down_drive !== want.down_drive ||
                   rsp_data.led_top !== want.led_top ||
                   rsp_data.led_mid !== want.led_mid ||
                   rsp_data.led_lower !== want.led_lower ||
                   rsp_data.moving !== want.moving ||
                   rsp_data.waiting !== want.waiting) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display({"%0t: levels differ (up down top mid bottom moving waiting)",
                               " expected %b %b %b %b %b %b %b got %b %b %b %b %b %b %b"},
                              $time, want.up_drive, want.down_drive, want.led_top,
                              want.led_mid, want.led_lower, want.moving, want.waiting,
                              rsp_data.up_drive, rsp_data.down_drive, rsp_data.led_top,
                              rsp_data.led_mid, rsp_data.led_lower, rsp_data.moving,
                              rsp_data.waiting);
               end
            end
         end

         if (req_valid && req_ready) begin
            case (req_data.operation)
               OP_TICK: begin
                  clock_ms = clock_ms + 1'b1;
                  elapsed = clock_ms - phase_since;
                  // of the dead time, run time and middle led rules only the first that applies takes effect
                  if (motion == PH_WAIT && elapsed >= dead_ms) begin
                     if (go_down) begin
                        drive_dir = DIR_DOWN;
                        set_led(SEL_BOTTOM, 1'b1);
                        relay_on[1] = 1'b1;
                        run_span = down_ms;
                     end else begin
                        drive_dir = DIR_UP;
                        set_led(SEL_TOP, 1'b1);
                        relay_on[0] = 1'b1;
                        run_span = up_ms;
                     end
                     phase_since = clock_ms;
                     motion = PH_MOVE;
                  end else if (motion == PH_MOVE && elapsed >= run_span) begin
                     motion_request(DIR_STOP, req_data.position_pct);
                  end else if (mid_pending && elapsed >= mid_ms) begin
                     set_led(SEL_MID, 1'b0);
                     mid_pending = 1'b0;
                  end
                  elapsed = clock_ms - blink_since;
                  if (blinking && elapsed >= TIME_W'(BLINK_PERIOD))
                     blink_apply(blink_sel, 1'b1);
               end
               OP_PRESS: begin
                  if (req_data.target_select != SEL_NONE && req_data.press_ms < short_ms) begin
                     case (req_data.target_select)
                        SEL_TOP: dir = DIR_UP;
                        SEL_MID: dir = DIR_STOP;
                        default: dir = DIR_DOWN;
                     endcase
                     motion_request(dir, req_data.position_pct);
                  end
               end
               OP_BLINK_START: blink_apply(req_data.target_select, 1'b1);
               default:        blink_apply(req_data.target_select, 1'b0);
            endcase
            want.up_drive = relay_on[0];
            want.down_drive = relay_on[1];
            want.led_top = led_on[SEL_TOP];
            want.led_mid = led_on[SEL_MID];
            want.led_lower = led_on[SEL_BOTTOM];
            want.moving = (motion == PH_MOVE);
            want.waiting = (motion == PH_WAIT);
            levels_due.push_back(want);
         end
      end
      pending_count = levels_due.size();
   end

endmodule

// ===== bench/blind_motor_relay_sequencer_unit_test.sv =====
`timescale 1ns / 100ps

module blind_motor_relay_sequencer_unit_test;
   import bmrs_pkg::*;

   // no item moved on either channel for this many cycles means the block is hung
   localparam int STALL_LIMIT = 2000;
   // receiver hold-off that fills the block and pushes back on the sender
   localparam int LONG_HOLD = 64;
   // quiet cycles after the last result, to catch stray results
   localparam int TAIL_CYCLES = 8;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_addr;
   logic [CSR_W-1:0]     csr_wdata;

   int fail_count;
   int pending_count;

   // idle percentages read by the sender and receiver
   int send_idle_pct;
   int recv_idle_pct;
   // long hold-off requests and how many the receiver has served
   int hold_asked = 0;
   int hold_served;
   int quiet_cycles;

   // copy of the timing registers, used to shape the stimulus
   logic [SHORT_W-1:0] dead_ms, mid_ms, short_ms;
   logic [RUN_W-1:0]   up_ms, down_ms;

   blind_motor_relay_sequencer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   blind_motor_relay_sequencer_unit_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic req_type make_item(input op_type op, input sel_type sel,
                                         input logic [PRESS_W-1:0] press,
                                         input logic [POS_W-1:0] pos);
      req_type item;
      item.operation = op;
      item.target_select = sel;
      item.press_ms = press;
      item.position_pct = pos;
      return item;
   endfunction

   // press lengths around the short-press limit plus the full range
   function automatic logic [PRESS_W-1:0] pick_press();
      case ($urandom_range(5))
         0: return PRESS_W'(0);
         1: return '1;
         2: return PRESS_W'(short_ms);
         3: return PRESS_W'($urandom());
         default: return (short_ms == 0) ? PRESS_W'(0) : PRESS_W'($urandom_range(short_ms - 1));
      endcase
   endfunction

   // both end positions, values past full, and the open range between
   function automatic logic [POS_W-1:0] pick_pos();
      case ($urandom_range(5))
         0: return POS_EMPTY;
         1: return POS_FULL;
         2: return POS_W'($urandom_range((1 << POS_W) - 1, POS_FULL + 1));
         default: return POS_W'($urandom_range(POS_FULL - 1, 1));
      endcase
   endfunction

   // a tick ignores every field but the operation, so those are random
   function automatic req_type tick_item();
      return make_item(OP_TICK, sel_type'($urandom_range(3)), pick_press(), pick_pos());
   endfunction

   function automatic req_type stray_item(input bit with_blink);
      return make_item(op_type'($urandom_range(with_blink ? 3 : 1)),
                       sel_type'($urandom_range(3)), pick_press(), pick_pos());
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input req_type item);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait until every outstanding result has been taken
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // all five registers on back-to-back cycles, only while the block is idle
   task automatic write_timing(input int dead, input int up, input int down, input int mid,
                               input int short_limit);
      csr_we <= 1'b1;
      csr_addr <= REG_DEAD_TIME;
      csr_wdata <= CSR_W'(dead);
      @(negedge clock);
      csr_addr <= REG_UP_RUN;
      csr_wdata <= CSR_W'(up);
      @(negedge clock);
      csr_addr <= REG_DOWN_RUN;
      csr_wdata <= CSR_W'(down);
      @(negedge clock);
      csr_addr <= REG_MID_LED;
      csr_wdata <= CSR_W'(mid);
      @(negedge clock);
      csr_addr <= REG_SHORT_PRESS;
      csr_wdata <= CSR_W'(short_limit);
      @(negedge clock);
      csr_we <= 1'b0;
      // the 16-bit registers keep only the low bits of the write
      dead_ms = SHORT_W'(dead);
      up_ms = RUN_W'(up);
      down_ms = RUN_W'(down);
      mid_ms = SHORT_W'(mid);
      short_ms = SHORT_W'(short_limit);
   endtask

   // mostly move sequences: a short press, then a random run of ticks, at most
   // enough to walk through dead time, run time and the middle led hold; the rest is noise
   task automatic run_traffic(input int count, input bit with_blink);
      int sent;
      int span;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 70) begin
            send_item(make_item(OP_PRESS, sel_type'($urandom_range(2)),
                                (short_ms == 0) ? PRESS_W'(0)
                                                : PRESS_W'($urandom_range(short_ms - 1)),
                                ($urandom_range(99) < 85)
                                   ? POS_W'($urandom_range(POS_FULL - 1, 1)) : pick_pos()));
            sent++;
            span = int'(dead_ms) + int'((up_ms > down_ms) ? up_ms : down_ms) + int'(mid_ms) + 3;
            if (span > 40) span = 40;
            repeat ($urandom_range(span)) begin
               if ($urandom_range(99) < 15) send_item(stray_item(with_blink));
               else send_item(tick_item());
               sent++;
            end
         end else begin
            send_item(stray_item(with_blink));
            sent++;
         end
      end
   endtask

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_served++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: cycles in which neither channel moves an item
   initial begin
      quiet_cycles = 0;
      @(negedge reset);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("blind_motor_relay_sequencer_unit verification failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      // sender idles a third of the time, receiver most of the time
      send_idle_pct = 33;
      recv_idle_pct = 60;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: short timings so every phase is reached in a few ticks
      write_timing(2, 4, 3, 2, 100);
      send_item(tick_item());
      send_item(make_item(OP_PRESS, SEL_TOP, '0, POS_FULL));      // up at the top end
      send_item(make_item(OP_PRESS, SEL_TOP, '0, '1));            // past full counts as full
      send_item(make_item(OP_PRESS, SEL_BOTTOM, '0, POS_EMPTY));  // down at the bottom end
      send_item(make_item(OP_PRESS, SEL_TOP, '1, 7'd50));         // saturated long press
      send_item(make_item(OP_PRESS, SEL_TOP, PRESS_W'(short_ms - 1), 7'd50)); // starts wait
      send_item(make_item(OP_PRESS, SEL_BOTTOM, '0, 7'd50));      // ignored while waiting
      repeat (2) send_item(tick_item());                          // dead time ends, moving up
      send_item(make_item(OP_PRESS, SEL_TOP, '0, 7'd60));         // same direction, ignored
      send_item(make_item(OP_PRESS, SEL_BOTTOM, '0, 7'd60));      // reverse stops, mid stays dark
      send_item(make_item(OP_PRESS, SEL_BOTTOM, '0, 7'd30));      // down wait
      send_item(make_item(OP_PRESS, SEL_MID, '0, 7'd30));         // stop cancels the wait
      repeat (2) send_item(tick_item());                          // mid led hold runs out
      send_item(make_item(OP_PRESS, SEL_BOTTOM, PRESS_W'(short_ms), 7'd1)); // at the limit
      send_item(make_item(OP_PRESS, SEL_NONE, '0, 7'd1));         // no button
      send_item(make_item(OP_PRESS, SEL_BOTTOM, '0, 7'd1));
      repeat (6) send_item(tick_item());                          // down run, then run-time stop
      send_item(make_item(OP_BLINK_START, SEL_NONE, '0, '0));     // blink on no led
      send_item(make_item(OP_BLINK_START, SEL_TOP, '0, '0));      // toggle, blink led unchanged
      send_item(make_item(OP_BLINK_STOP, SEL_MID, '0, '0));
      send_item(make_item(OP_BLINK_START, SEL_BOTTOM, '1, '1));
      send_item(make_item(OP_BLINK_STOP, SEL_NONE, '0, '0));

      drain_results();
      write_timing($urandom_range(6), $urandom_range(12), $urandom_range(12),
                   $urandom_range(8), $urandom_range(800));
      run_traffic(200, 1'b1);

      // zero timings: everything fires on the next tick
      drain_results();
      write_timing(0, 0, 0, 0, 800);
      run_traffic(100, 1'b1);

      // roles swapped; the long hold-off lands early in this phase
      drain_results();
      send_idle_pct = 60;
      recv_idle_pct = 33;
      write_timing($urandom_range(6), $urandom_range(12), $urandom_range(12),
                   $urandom_range(8), $urandom_range(800));
      hold_asked++;
      run_traffic(200, 1'b1);

      // all ones, wider than the 16-bit registers
      drain_results();
      write_timing('1, '1, '1, '1, '1);
      run_traffic(120, 1'b1);

      // no idling; a blink with no blink items after it, so it free-runs
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_timing($urandom_range(6), $urandom_range(12), $urandom_range(12),
                   $urandom_range(8), $urandom_range(800));
      send_item(make_item(OP_BLINK_START, sel_type'($urandom_range(3)), pick_press(), pick_pos()));
      run_traffic(720, 1'b0);

      drain_results();
      write_timing($urandom_range(6), $urandom_range(12), $urandom_range(12),
                   $urandom_range(8), $urandom_range(800));
      run_traffic(250, 1'b1);

      // a zero press limit: no press acts
      drain_results();
      write_timing(1, 2, 2, 1, 0);
      run_traffic(60, 1'b1);

      drain_results();
      write_timing($urandom_range(40), $urandom_range(300), $urandom_range(300),
                   $urandom_range(60), $urandom());
      run_traffic(200, 1'b1);

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("blind_motor_relay_sequencer_unit verification clean");
      else
         $display("blind_motor_relay_sequencer_unit verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/bmrs_pkg.sv
hdl/blind_motor_relay_sequencer_unit.sv
hdl/bmrs_checker.sv
bench/blind_motor_relay_sequencer_unit_checker.sv
bench/blind_motor_relay_sequencer_unit_test.sv
